FILE: sv/pfb_pkg.sv
`default_nettype none

package pfb_pkg;

    localparam int TEX_W    = 16;
    localparam int IDX16_W  = 16;
    localparam int STATE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int REM_W    = 6;
    localparam int NIDX_W   = 8;
    localparam int BIDX_W   = 14;
    localparam int BVTX_W   = 13;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_COPY_MODE     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LIGHTMAP_VIEW = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WHITE_TEXTURE = 2'd2;

    localparam logic OP_DRAW  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic KIND_TRI   = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic [COUNT_W-1:0] MIN_POLY_VERTICES = 7'd3;

    typedef struct packed {
        logic capture;
        logic eval;
        logic flush_load;
        logic commit;
        logic tri_load;
    } pfb_cmd_t;

    typedef struct packed {
        logic degenerate;
        logic flush_op;
        logic emit_flush;
        logic tri_last;
        logic out_free;
    } pfb_status_t;

endpackage

`default_nettype wire

FILE: sv/pfb_ctrl.sv
`default_nettype none

module pfb_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire pfb_pkg::pfb_status_t status,
    output pfb_pkg::pfb_cmd_t        cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_ACT  = 2'd2;
    localparam logic [1:0] ST_TRI  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = ST_ACT;
            end
            ST_ACT: begin
                if (status.degenerate) begin
                    state_next = ST_IDLE;
                end else if (!status.emit_flush || status.out_free) begin
                    // flush result leaves with the old batch, then update it
                    cmd.flush_load = status.emit_flush;
                    cmd.commit     = 1'b1;
                    state_next     = status.flush_op ? ST_IDLE : ST_TRI;
                end
            end
            ST_TRI: begin
                if (status.out_free) begin
                    cmd.tri_load = 1'b1;
                    if (status.tri_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pfb_datapath.sv
`default_nettype none

module pfb_datapath #(
    parameter int MAX_INDICES       = 8192,
    parameter int MAX_VERTICES      = 4096,
    parameter int MAX_POLY_VERTICES = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire pfb_pkg::pfb_cmd_t                 cmd,
    output pfb_pkg::pfb_status_t                   status,
    input  wire logic                              copy_mode,
    input  wire logic                              lightmap_view,
    input  wire logic [pfb_pkg::TEX_W-1:0]         white_texture,
    input  wire logic                              s_operation,
    input  wire logic [pfb_pkg::IDX16_W-1:0]       s_first_vertex,
    input  wire logic [pfb_pkg::COUNT_W-1:0]       s_vertex_count,
    input  wire logic [pfb_pkg::TEX_W-1:0]         s_base_texture,
    input  wire logic [pfb_pkg::TEX_W-1:0]         s_light_texture,
    input  wire logic [pfb_pkg::STATE_W-1:0]       s_render_state,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_kind,
    output logic [pfb_pkg::IDX16_W-1:0]            m_index_a,
    output logic [pfb_pkg::IDX16_W-1:0]            m_index_b,
    output logic [pfb_pkg::IDX16_W-1:0]            m_index_c,
    output logic [pfb_pkg::BIDX_W-1:0]             m_batch_indices,
    output logic [pfb_pkg::BVTX_W-1:0]             m_batch_vertices,
    output logic [pfb_pkg::TEX_W-1:0]              m_batch_base_texture,
    output logic [pfb_pkg::TEX_W-1:0]              m_batch_light_texture,
    output logic [pfb_pkg::STATE_W-1:0]            m_batch_state,
    output logic                                   m_last
);

    localparam int IDX_W = $clog2(MAX_INDICES + 1);
    localparam int VTX_W = $clog2(MAX_VERTICES + 1);

    // captured item
    logic                          op_reg;
    logic [pfb_pkg::IDX16_W-1:0]   first_reg;
    logic [pfb_pkg::COUNT_W-1:0]   cnt_reg;
    logic [pfb_pkg::TEX_W-1:0]     btex_reg;
    logic [pfb_pkg::TEX_W-1:0]     ltex_reg;
    logic [pfb_pkg::STATE_W-1:0]   sbits_reg;
    logic                          degen_reg;
    logic [pfb_pkg::COUNT_W-1:0]   cnt_sat;
    logic [pfb_pkg::TEX_W-1:0]     btex_sel;

    // decision flags
    logic flush_cond_reg;
    logic emit_flush_reg;

    // batch state
    logic [pfb_pkg::TEX_W-1:0]     cur_base_reg, cur_base_next;
    logic [pfb_pkg::TEX_W-1:0]     cur_light_reg, cur_light_next;
    logic [pfb_pkg::STATE_W-1:0]   cur_state_reg, cur_state_next;
    logic [IDX_W-1:0]              index_total_reg, index_total_next;
    logic [VTX_W-1:0]              vertex_total_reg, vertex_total_next;

    // fan walk
    logic [pfb_pkg::IDX16_W-1:0]   apex_reg, apex_next;
    logic [pfb_pkg::IDX16_W-1:0]   b_run_reg, b_run_next;
    logic [pfb_pkg::REM_W-1:0]     rem_reg, rem_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic                          kind_reg;
    logic [pfb_pkg::IDX16_W-1:0]   idx_a_reg, idx_b_reg, idx_c_reg;
    logic [pfb_pkg::BIDX_W-1:0]    bidx_reg;
    logic [pfb_pkg::BVTX_W-1:0]    bvtx_reg;
    logic [pfb_pkg::TEX_W-1:0]     bbase_reg, blight_reg;
    logic [pfb_pkg::STATE_W-1:0]   bstate_reg;
    logic                          last_reg;

    logic [pfb_pkg::COUNT_W-1:0]   ntris;
    logic [pfb_pkg::NIDX_W-1:0]    nidx;
    logic                          mismatch;
    logic [IDX_W:0]                idx_sum;
    logic [VTX_W:0]                vtx_sum;
    logic                          flush_cond_eval;
    logic [IDX_W-1:0]              idx_base;
    logic [VTX_W-1:0]              vtx_base;
    logic [pfb_pkg::IDX16_W-1:0]   apex_calc;
    logic                          out_free;

    assign cnt_sat  = (s_vertex_count > pfb_pkg::COUNT_W'(MAX_POLY_VERTICES))
                    ? pfb_pkg::COUNT_W'(MAX_POLY_VERTICES) : s_vertex_count;
    assign btex_sel = (lightmap_view && (s_light_texture != '0))
                    ? white_texture : s_base_texture;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_operation;
            first_reg <= s_first_vertex;
            cnt_reg   <= cnt_sat;
            btex_reg  <= btex_sel;
            ltex_reg  <= s_light_texture;
            sbits_reg <= s_render_state;
            degen_reg <= (s_operation == pfb_pkg::OP_DRAW)
                      && (s_vertex_count < pfb_pkg::MIN_POLY_VERTICES);
        end
    end

    assign ntris    = cnt_reg - 7'd2;
    assign nidx     = (pfb_pkg::NIDX_W'(ntris) << 1) + pfb_pkg::NIDX_W'(ntris);
    assign mismatch = (cur_base_reg != btex_reg) || (cur_light_reg != ltex_reg)
                   || (cur_state_reg != sbits_reg);
    assign idx_sum  = (IDX_W+1)'(index_total_reg) + (IDX_W+1)'(nidx);
    assign vtx_sum  = (VTX_W+1)'(vertex_total_reg) + (VTX_W+1)'(cnt_reg);

    // a vertex overflow after a main flush cannot happen, so OR the two
    assign flush_cond_eval = mismatch || (idx_sum > (IDX_W+1)'(MAX_INDICES))
                          || (copy_mode && (vtx_sum > (VTX_W+1)'(MAX_VERTICES)));

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            flush_cond_reg <= flush_cond_eval;
            emit_flush_reg <= (op_reg || flush_cond_eval) && (index_total_reg != '0);
        end
    end

    assign idx_base  = flush_cond_reg ? '0 : index_total_reg;
    assign vtx_base  = flush_cond_reg ? '0 : vertex_total_reg;
    assign apex_calc = copy_mode ? pfb_pkg::IDX16_W'(vtx_base) : first_reg;

    always_comb begin
        cur_base_next     = cur_base_reg;
        cur_light_next    = cur_light_reg;
        cur_state_next    = cur_state_reg;
        index_total_next  = index_total_reg;
        vertex_total_next = vertex_total_reg;
        apex_next         = apex_reg;
        b_run_next        = b_run_reg;
        rem_next          = rem_reg;
        if (cmd.commit) begin
            if (op_reg == pfb_pkg::OP_FLUSH) begin
                cur_base_next     = '0;
                cur_light_next    = '0;
                cur_state_next    = '0;
                index_total_next  = '0;
                vertex_total_next = '0;
            end else begin
                cur_base_next     = btex_reg;
                cur_light_next    = ltex_reg;
                cur_state_next    = sbits_reg;
                index_total_next  = idx_base + IDX_W'(nidx);
                vertex_total_next = copy_mode ? vtx_base + VTX_W'(cnt_reg) : vtx_base;
                apex_next         = apex_calc;
                b_run_next        = apex_calc + 16'd1;
                rem_next          = pfb_pkg::REM_W'(ntris);
            end
        end else if (cmd.tri_load) begin
            b_run_next = b_run_reg + 16'd1;
            rem_next   = rem_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_base_reg     <= '0;
            cur_light_reg    <= '0;
            cur_state_reg    <= '0;
            index_total_reg  <= '0;
            vertex_total_reg <= '0;
            rem_reg          <= '0;
        end else begin
            cur_base_reg     <= cur_base_next;
            cur_light_reg    <= cur_light_next;
            cur_state_reg    <= cur_state_next;
            index_total_reg  <= index_total_next;
            vertex_total_reg <= vertex_total_next;
            rem_reg          <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        apex_reg  <= apex_next;
        b_run_reg <= b_run_next;
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.flush_load || cmd.tri_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.flush_load) begin
            kind_reg   <= pfb_pkg::KIND_FLUSH;
            idx_a_reg  <= '0;
            idx_b_reg  <= '0;
            idx_c_reg  <= '0;
            bidx_reg   <= pfb_pkg::BIDX_W'(index_total_reg);
            bvtx_reg   <= pfb_pkg::BVTX_W'(vertex_total_reg);
            bbase_reg  <= cur_base_reg;
            blight_reg <= cur_light_reg;
            bstate_reg <= cur_state_reg;
            last_reg   <= op_reg;
        end else if (cmd.tri_load) begin
            kind_reg   <= pfb_pkg::KIND_TRI;
            idx_a_reg  <= apex_reg;
            idx_b_reg  <= b_run_reg;
            idx_c_reg  <= b_run_reg + 16'd1;
            bidx_reg   <= '0;
            bvtx_reg   <= '0;
            bbase_reg  <= '0;
            blight_reg <= '0;
            bstate_reg <= '0;
            last_reg   <= (rem_reg == 6'd1);
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_kind                = kind_reg;
    assign m_index_a             = idx_a_reg;
    assign m_index_b             = idx_b_reg;
    assign m_index_c             = idx_c_reg;
    assign m_batch_indices       = bidx_reg;
    assign m_batch_vertices      = bvtx_reg;
    assign m_batch_base_texture  = bbase_reg;
    assign m_batch_light_texture = blight_reg;
    assign m_batch_state         = bstate_reg;
    assign m_last                = last_reg;

    assign status.degenerate = degen_reg;
    assign status.flush_op   = (op_reg == pfb_pkg::OP_FLUSH);
    assign status.emit_flush = emit_flush_reg;
    assign status.tri_last   = (rem_reg == 6'd1);
    assign status.out_free   = out_free;

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        index_total_reg <= IDX_W'(MAX_INDICES))
        else $error("index total above store size");

    a_vertex_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vertex_total_reg <= VTX_W'(MAX_VERTICES))
        else $error("vertex total above store size");

    a_flush_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush_load |-> (index_total_reg != '0))
        else $error("flush of an empty batch");

    a_tri_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tri_load |-> (rem_reg != '0) && out_free)
        else $error("triangle load with none left or output busy");

endmodule

`default_nettype wire

FILE: sv/polygon_fan_batcher.sv
// Triangle fan to triangle-list batcher.
// Input channel (s_*): one item per transfer, either a draw polygon (first
// vertex, vertex count, textures, render state) or a flush request.
// Result channel (m_*): an optional batch-flush result, then count-2 triangle
// index triples; m_last marks the final result of an item. A flush item
// or a polygon with fewer than three vertices may produce no result at all.
// Configuration: APB registers copy_mode (0x0), lightmap_view (0x4) and
// white_texture (0x8); write them only while the block is idle.
// Sequence: an item is captured on transfer (IDLE), evaluated in EVAL, the
// flush result (if any) is loaded with the commit in ACT, then TRI loads one
// triangle per cycle while the output register is free. A polygon of n
// vertices yields n-2 triangles after capture, compare and commit; a flush
// or dropped item ends after ACT. The sequencer handles one item at a
// time. The results sit in a single output register; while it is full and
// m_ready is low the sequencer holds and no result is lost.
// Reset (aresetn low, synchronous) clears the registers, the batch textures,
// state bits and counts, and empties the output register.
`default_nettype none

module polygon_fan_batcher #(
    parameter int MAX_INDICES       = 8192,
    parameter int MAX_VERTICES      = 4096,
    parameter int MAX_POLY_VERTICES = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pfb_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [pfb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pfb_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_operation,
    input  wire logic [pfb_pkg::IDX16_W-1:0]       s_first_vertex,
    input  wire logic [pfb_pkg::COUNT_W-1:0]       s_vertex_count,
    input  wire logic [pfb_pkg::TEX_W-1:0]         s_base_texture,
    input  wire logic [pfb_pkg::TEX_W-1:0]         s_light_texture,
    input  wire logic [pfb_pkg::STATE_W-1:0]       s_render_state,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_kind,
    output logic [pfb_pkg::IDX16_W-1:0]            m_index_a,
    output logic [pfb_pkg::IDX16_W-1:0]            m_index_b,
    output logic [pfb_pkg::IDX16_W-1:0]            m_index_c,
    output logic [pfb_pkg::BIDX_W-1:0]             m_batch_indices,
    output logic [pfb_pkg::BVTX_W-1:0]             m_batch_vertices,
    output logic [pfb_pkg::TEX_W-1:0]              m_batch_base_texture,
    output logic [pfb_pkg::TEX_W-1:0]              m_batch_light_texture,
    output logic [pfb_pkg::STATE_W-1:0]            m_batch_state,
    output logic                                   m_last
);

    logic                          copy_mode_reg, copy_mode_next;
    logic                          lightmap_view_reg, lightmap_view_next;
    logic [pfb_pkg::TEX_W-1:0]     white_texture_reg, white_texture_next;
    logic                          cfg_write;
    logic [pfb_pkg::REG_IDX_W-1:0] reg_idx;

    pfb_pkg::pfb_cmd_t    cmd;
    pfb_pkg::pfb_status_t status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = paddr[pfb_pkg::APB_ADDR_W-1:2];

    always_comb begin
        copy_mode_next     = copy_mode_reg;
        lightmap_view_next = lightmap_view_reg;
        white_texture_next = white_texture_reg;
        if (cfg_write) begin
            unique case (reg_idx)
                pfb_pkg::REG_COPY_MODE:     copy_mode_next     = pwdata[0];
                pfb_pkg::REG_LIGHTMAP_VIEW: lightmap_view_next = pwdata[0];
                pfb_pkg::REG_WHITE_TEXTURE: white_texture_next = pwdata[pfb_pkg::TEX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            copy_mode_reg     <= 1'b0;
            lightmap_view_reg <= 1'b0;
            white_texture_reg <= '0;
        end else begin
            copy_mode_reg     <= copy_mode_next;
            lightmap_view_reg <= lightmap_view_next;
            white_texture_reg <= white_texture_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            pfb_pkg::REG_COPY_MODE:     prdata = pfb_pkg::APB_DATA_W'(copy_mode_reg);
            pfb_pkg::REG_LIGHTMAP_VIEW: prdata = pfb_pkg::APB_DATA_W'(lightmap_view_reg);
            pfb_pkg::REG_WHITE_TEXTURE: prdata = pfb_pkg::APB_DATA_W'(white_texture_reg);
            default:                    prdata = '0;
        endcase
    end

    pfb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pfb_datapath #(
        .MAX_INDICES       (MAX_INDICES),
        .MAX_VERTICES      (MAX_VERTICES),
        .MAX_POLY_VERTICES (MAX_POLY_VERTICES)
    ) u_datapath (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .status                (status),
        .copy_mode             (copy_mode_reg),
        .lightmap_view         (lightmap_view_reg),
        .white_texture         (white_texture_reg),
        .s_operation           (s_operation),
        .s_first_vertex        (s_first_vertex),
        .s_vertex_count        (s_vertex_count),
        .s_base_texture        (s_base_texture),
        .s_light_texture       (s_light_texture),
        .s_render_state        (s_render_state),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_kind                (m_kind),
        .m_index_a             (m_index_a),
        .m_index_b             (m_index_b),
        .m_index_c             (m_index_c),
        .m_batch_indices       (m_batch_indices),
        .m_batch_vertices      (m_batch_vertices),
        .m_batch_base_texture  (m_batch_base_texture),
        .m_batch_light_texture (m_batch_light_texture),
        .m_batch_state         (m_batch_state),
        .m_last                (m_last)
    );

endmodule

`default_nettype wire

FILE: sim/polygon_fan_batcher_test.sv
`default_nettype none

module polygon_fan_batcher_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pfb_pkg::*;

    localparam int MAX_INDICES       = 8192;
    localparam int MAX_VERTICES      = 4096;
    localparam int MAX_POLY_VERTICES = 64;
    localparam int SETTLE_CYCLES     = 12;
    localparam int IDLE_PERCENT      = 24;
    localparam int RANDOM_ITEMS      = 80;

    typedef struct packed {
        logic                operation;
        logic [IDX16_W-1:0]  first_vertex;
        logic [COUNT_W-1:0]  vertex_count;
        logic [TEX_W-1:0]    base_texture;
        logic [TEX_W-1:0]    light_texture;
        logic [STATE_W-1:0]  render_state;
    } polygon_t;

    typedef struct packed {
        logic                kind;
        logic [IDX16_W-1:0]  index_a;
        logic [IDX16_W-1:0]  index_b;
        logic [IDX16_W-1:0]  index_c;
        logic [BIDX_W-1:0]   batch_indices;
        logic [BVTX_W-1:0]   batch_vertices;
        logic [TEX_W-1:0]    batch_base_texture;
        logic [TEX_W-1:0]    batch_light_texture;
        logic [STATE_W-1:0]  batch_state;
        logic                last;
    } fan_result_t;

    // Tracks the open batch and the triangle/flush results each polygon should produce.
    class fan_scoreboard;
        bit                 copy_mode;
        bit                 lightmap_view;
        logic [TEX_W-1:0]   white_texture;
        logic [TEX_W-1:0]   batch_base;
        logic [TEX_W-1:0]   batch_light;
        logic [STATE_W-1:0] batch_bits;
        int                 index_total;
        int                 vertex_total;
        int                 mismatches;
        fan_result_t        pending_results[$];

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endfunction

        function string describe(fan_result_t r);
            return $sformatf({"kind=%0d tri=(%0d,%0d,%0d) batch idx=%0d vtx=%0d ",
                              "tex=%0h/%0h state=%0h last=%0d"},
                             r.kind, r.index_a, r.index_b, r.index_c, r.batch_indices,
                             r.batch_vertices, r.batch_base_texture, r.batch_light_texture,
                             r.batch_state, r.last);
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_COPY_MODE: begin
                    copy_mode = value[0];
                end
                REG_LIGHTMAP_VIEW: begin
                    lightmap_view = value[0];
                end
                REG_WHITE_TEXTURE: begin
                    white_texture = value[TEX_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void push_batch_flush(bit last);
            fan_result_t r;
            r = '0;
            r.kind                = KIND_FLUSH;
            r.batch_indices       = index_total[BIDX_W-1:0];
            r.batch_vertices      = vertex_total[BVTX_W-1:0];
            r.batch_base_texture  = batch_base;
            r.batch_light_texture = batch_light;
            r.batch_state         = batch_bits;
            r.last                = last;
            pending_results.push_back(r);
        endfunction

        function void note_item(polygon_t p);
            int               count;
            int               ntris;
            int               apex;
            logic [TEX_W-1:0] btex;
            fan_result_t      r;
            if (p.operation == OP_FLUSH) begin
                if (index_total != 0) begin
                    push_batch_flush(1'b1);
                end
                index_total  = 0;
                vertex_total = 0;
                batch_base   = '0;
                batch_light  = '0;
                batch_bits   = '0;
                return;
            end
            count = int'(p.vertex_count);
            if (count < int'(MIN_POLY_VERTICES)) begin
                return;
            end
            if (count > MAX_POLY_VERTICES) begin
                count = MAX_POLY_VERTICES;
            end
            ntris = count - 2;
            btex = (lightmap_view && p.light_texture != '0) ? white_texture : p.base_texture;
            if (batch_base != btex || batch_light != p.light_texture ||
                batch_bits != p.render_state || index_total + 3 * ntris > MAX_INDICES) begin
                if (index_total != 0) begin
                    push_batch_flush(1'b0);
                end
                index_total  = 0;
                vertex_total = 0;
            end
            batch_base  = btex;
            batch_light = p.light_texture;
            batch_bits  = p.render_state;
            if (copy_mode) begin
                // vertex store overflow keeps the batch textures and state
                if (vertex_total + count > MAX_VERTICES) begin
                    if (index_total != 0) begin
                        push_batch_flush(1'b0);
                    end
                    index_total  = 0;
                    vertex_total = 0;
                end
                apex = vertex_total;
                vertex_total += count;
            end else begin
                apex = int'(p.first_vertex);
            end
            for (int i = 0; i < ntris; i++) begin
                r = '0;
                r.kind    = KIND_TRI;
                r.index_a = apex[IDX16_W-1:0];
                r.index_b = IDX16_W'(apex + i + 1);
                r.index_c = IDX16_W'(apex + i + 2);
                r.last    = (i == ntris - 1);
                pending_results.push_back(r);
            end
            index_total += 3 * ntris;
        endfunction

        function void check_result(fan_result_t got);
            fan_result_t want;
            if (pending_results.size() == 0) begin
                flag({"result with nothing pending: ", describe(got)});
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                flag({"expected ", describe(want), " got ", describe(got)});
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_operation;
    logic [IDX16_W-1:0]     s_first_vertex;
    logic [COUNT_W-1:0]     s_vertex_count;
    logic [TEX_W-1:0]       s_base_texture;
    logic [TEX_W-1:0]       s_light_texture;
    logic [STATE_W-1:0]     s_render_state;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_kind;
    logic [IDX16_W-1:0]     m_index_a;
    logic [IDX16_W-1:0]     m_index_b;
    logic [IDX16_W-1:0]     m_index_c;
    logic [BIDX_W-1:0]      m_batch_indices;
    logic [BVTX_W-1:0]      m_batch_vertices;
    logic [TEX_W-1:0]       m_batch_base_texture;
    logic [TEX_W-1:0]       m_batch_light_texture;
    logic [STATE_W-1:0]     m_batch_state;
    logic                   m_last;

    fan_scoreboard sb = new();
    bit            steady = 1'b0;

    polygon_fan_batcher #(
        .MAX_INDICES       (MAX_INDICES),
        .MAX_VERTICES      (MAX_VERTICES),
        .MAX_POLY_VERTICES (MAX_POLY_VERTICES)
    ) dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_operation           (s_operation),
        .s_first_vertex        (s_first_vertex),
        .s_vertex_count        (s_vertex_count),
        .s_base_texture        (s_base_texture),
        .s_light_texture       (s_light_texture),
        .s_render_state        (s_render_state),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_kind                (m_kind),
        .m_index_a             (m_index_a),
        .m_index_b             (m_index_b),
        .m_index_c             (m_index_c),
        .m_batch_indices       (m_batch_indices),
        .m_batch_vertices      (m_batch_vertices),
        .m_batch_base_texture  (m_batch_base_texture),
        .m_batch_light_texture (m_batch_light_texture),
        .m_batch_state         (m_batch_state),
        .m_last                (m_last)
    );

    always #1 aclk = ~aclk;

    function bit idle_now();
        return !steady && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = !idle_now();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result({m_kind, m_index_a, m_index_b, m_index_c, m_batch_indices,
                             m_batch_vertices, m_batch_base_texture, m_batch_light_texture,
                             m_batch_state, m_last});
        end
    end

    // Write the register, or read it back and compare.
    task apb_transfer(input bit do_write, input logic [REG_IDX_W-1:0] idx,
                      input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] mask;
        mask = (idx == REG_WHITE_TEXTURE) ? {{(APB_DATA_W-TEX_W){1'b0}}, {TEX_W{1'b1}}}
                                          : APB_DATA_W'(1);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = do_write;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (do_write) begin
            sb.set_reg(idx, value);
        end else if ((prdata & mask) !== (value & mask)) begin
            sb.flag($sformatf("register %0d read %0h, expected %0h", idx, prdata, value));
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task program_regs(input bit copy, input bit lview, input logic [TEX_W-1:0] white);
        apb_transfer(1'b1, REG_COPY_MODE, APB_DATA_W'(copy));
        apb_transfer(1'b1, REG_LIGHTMAP_VIEW, APB_DATA_W'(lview));
        apb_transfer(1'b1, REG_WHITE_TEXTURE, APB_DATA_W'(white));
        apb_transfer(1'b0, REG_COPY_MODE, APB_DATA_W'(copy));
        apb_transfer(1'b0, REG_LIGHTMAP_VIEW, APB_DATA_W'(lview));
        apb_transfer(1'b0, REG_WHITE_TEXTURE, APB_DATA_W'(white));
    endtask

    task send_item(input polygon_t p);
        @(negedge aclk);
        while (idle_now()) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_operation     = p.operation;
        s_first_vertex  = p.first_vertex;
        s_vertex_count  = p.vertex_count;
        s_base_texture  = p.base_texture;
        s_light_texture = p.light_texture;
        s_render_state  = p.render_state;
        s_valid         = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(p);
    endtask

    // Drop valid, let every pending result drain, then give the sequencer time to go idle.
    task wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function polygon_t draw(logic [IDX16_W-1:0] first, logic [COUNT_W-1:0] count,
                            logic [TEX_W-1:0] btex, logic [TEX_W-1:0] ltex,
                            logic [STATE_W-1:0] bits);
        return {OP_DRAW, first, count, btex, ltex, bits};
    endfunction

    function polygon_t flush_req();
        return {OP_FLUSH, IDX16_W'($urandom), COUNT_W'($urandom), TEX_W'($urandom),
                TEX_W'($urandom), STATE_W'($urandom)};
    endfunction

    function logic [COUNT_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) begin
            return COUNT_W'($urandom_range(10, 3));
        end else if (roll < 85) begin
            return COUNT_W'($urandom_range(63, 11));
        end else if (roll < 92) begin
            return COUNT_W'(MAX_POLY_VERTICES);
        end
        return COUNT_W'($urandom_range(127, 65));
    endfunction

    // Runs of polygons sharing textures and state, with flushes and dropped polygons mixed in.
    task random_phase(input int n_items);
        logic [TEX_W-1:0]   base_pool[4];
        logic [TEX_W-1:0]   light_pool[4];
        logic [STATE_W-1:0] state_pool[4];
        logic [TEX_W-1:0]   btex;
        logic [TEX_W-1:0]   ltex;
        logic [STATE_W-1:0] bits;
        polygon_t           p;
        int                 taken;
        int                 roll;
        foreach (base_pool[j]) begin
            base_pool[j]  = TEX_W'($urandom);
            light_pool[j] = (j == 0) ? '0 : TEX_W'($urandom);
            state_pool[j] = STATE_W'($urandom);
        end
        taken = 0;
        while (taken < n_items) begin
            btex = base_pool[2'($urandom_range(3))];
            ltex = light_pool[2'($urandom_range(3))];
            bits = state_pool[2'($urandom_range(3))];
            if ($urandom_range(9) == 0) begin
                btex = TEX_W'($urandom);
                ltex = TEX_W'($urandom);
                bits = STATE_W'($urandom);
            end
            repeat ($urandom_range(8, 1)) begin
                roll = $urandom_range(99);
                if (roll < 5) begin
                    p = flush_req();
                end else if (roll < 8) begin
                    p = draw(IDX16_W'($urandom), COUNT_W'($urandom_range(2)), btex, ltex, bits);
                end else begin
                    p = draw(IDX16_W'($urandom), pick_count(), btex, ltex, bits);
                end
                send_item(p);
                if (roll >= 8 || roll < 5) begin
                    taken++;
                end
            end
        end
        wait_drained();
    endtask

    initial begin
        logic [STATE_W-1:0] fixed_bits;
        aresetn         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        s_valid         = 1'b0;
        s_operation     = OP_DRAW;
        s_first_vertex  = '0;
        s_vertex_count  = '0;
        s_base_texture  = '0;
        s_light_texture = '0;
        s_render_state  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        program_regs(1'b0, 1'b0, '0);
        send_item(flush_req());                                  // empty batch: nothing out
        send_item(draw('0, COUNT_W'(3), '0, '0, '0));            // matches reset batch
        send_item(draw(16'hFFFF, COUNT_W'(64), '0, '0, '0));     // indices wrap
        send_item(draw(IDX16_W'($urandom), COUNT_W'(0), 16'h1, '0, '0));   // degenerate
        send_item(draw(IDX16_W'($urandom), COUNT_W'(1), 16'h1, '0, '0));
        send_item(draw(IDX16_W'($urandom), COUNT_W'(2), 16'h1, '0, '0));
        send_item(draw(16'hFFC0, COUNT_W'(127), 16'h1, '0, '0)); // new base texture, saturate
        send_item(draw(IDX16_W'($urandom), COUNT_W'(65), 16'h1, 16'h1, '0));
        send_item(draw(IDX16_W'($urandom), COUNT_W'(5), 16'h1, 16'h1, 32'hFFFF_FFFF));
        send_item(draw(16'hFFFF, COUNT_W'(3), 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(draw('0, COUNT_W'(10), 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(flush_req());
        send_item(flush_req());
        wait_drained();

        program_regs(1'b1, 1'b1, 16'hFFFF);
        send_item(flush_req());
        send_item(draw(16'h1234, COUNT_W'(5), 16'h00AA, '0, 32'h5));     // no lightmap
        send_item(draw(16'h1234, COUNT_W'(4), 16'h00AA, 16'h55, 32'h5)); // white substituted
        send_item(draw(IDX16_W'($urandom), COUNT_W'(3), TEX_W'($urandom), 16'h55, 32'h5));
        send_item(flush_req());
        wait_drained();

        // Fill the index store until no further triangle fits, then overflow it.
        program_regs(1'b0, 1'b0, TEX_W'($urandom));
        steady = 1'b1;
        fixed_bits = STATE_W'($urandom);
        send_item(flush_req());
        while (sb.index_total + 3 * (MAX_POLY_VERTICES - 2) <= MAX_INDICES) begin
            send_item(draw(IDX16_W'($urandom), COUNT_W'(MAX_POLY_VERTICES), 16'h77, 16'h88,
                           fixed_bits));
        end
        while (sb.index_total + 6 <= MAX_INDICES) begin
            send_item(draw(IDX16_W'($urandom), COUNT_W'(4), 16'h77, 16'h88, fixed_bits));
        end
        send_item(draw(IDX16_W'($urandom), COUNT_W'(3), 16'h77, 16'h88, fixed_bits));
        send_item(draw(IDX16_W'($urandom), COUNT_W'(6), 16'h77, 16'h88, fixed_bits));
        wait_drained();
        steady = 1'b0;

        program_regs(1'b0, 1'b0, TEX_W'($urandom));
        random_phase(RANDOM_ITEMS);
        program_regs(1'b1, 1'b1, 16'hFFFF);
        random_phase(RANDOM_ITEMS);
        steady = 1'b1;
        program_regs(1'b0, 1'b1, TEX_W'($urandom));
        random_phase(RANDOM_ITEMS);
        steady = 1'b0;
        program_regs(1'b1, 1'b0, '0);
        random_phase(RANDOM_ITEMS);

        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("polygon_fan_batcher_test: clean");
        end else begin
            $display("polygon_fan_batcher_test: errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("polygon_fan_batcher_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
